// ===== hdl/lzbm_pkg.sv =====
// Package for the lux zone brightness mapper: widths, zone word layout,
// sequencer states and the helpers for the base-2 logarithm.
// No dependencies.
package lzbm_pkg;

    localparam int MAX_ZONES     = 6;
    localparam int LUX_FRAC_BITS = 4;
    localparam int LOG_FRAC_BITS = 12;

    localparam int LUX_IN_W    = 21;
    localparam int LUX_W       = 20;
    localparam int PCT_W       = 7;
    localparam int HYST_W      = 7;
    localparam int ZIDX_W      = 3;
    localparam int ZONE_WORD_W = 55;
    localparam int CFG_IDX_W   = 3;

    localparam int MANT_BITS = 30;
    localparam int MANT_W    = MANT_BITS + 1;
    localparam int PROD_W    = 2 * MANT_W;
    localparam int POS_W     = $clog2(LUX_W + 1);
    localparam int LOG_W     = $clog2((LUX_W + 1) << LOG_FRAC_BITS);
    localparam int STEP_W    = $clog2(LOG_FRAC_BITS);
    localparam int DIVD_W    = LUX_W + PCT_W;
    localparam int QCNT_W    = $clog2(DIVD_W);
    localparam int RES_W     = DIVD_W + 2;
    localparam int LUX100_W  = LUX_W + 7;

    localparam int PCT_FULL = 100;
    localparam int LUX_ONE  = 1 << LUX_FRAC_BITS;
    localparam int LOG_ONE  = LUX_FRAC_BITS << LOG_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_ZONE_WORD_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONES_IN_USE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 3'd7;

    typedef struct packed {
        logic             curve_log;
        logic [PCT_W-1:0] pct_hi;
        logic [PCT_W-1:0] pct_lo;
        logic [LUX_W-1:0] lux_max;
        logic [LUX_W-1:0] lux_min;
    } zone_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HYST_LO,
        ST_HYST_HI,
        ST_HYST_CHK,
        ST_SEARCH,
        ST_MAP,
        ST_LOG_SQ,
        ST_LOG_ADJ,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    // Position of the leading one of a nonzero value.
    function automatic logic [POS_W-1:0] msb_pos(input logic [LUX_W:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i <= LUX_W; i++) begin
            if (x[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    // Mantissa with the leading one moved to bit MANT_BITS.
    function automatic logic [MANT_W-1:0] normalize(input logic [LUX_W:0] x);
        logic [POS_W-1:0] p;
        p = msb_pos(x);
        return MANT_W'(x) << (MANT_BITS - int'(p));
    endfunction

endpackage

// ===== hdl/lux_zone_brightness_mapper.sv =====
// Top level of the lux zone brightness mapper: zone registers, zone
// selection with hysteresis, and the curve sequencer. Depends on lzbm_pkg.
// Each lux sample transaction selects one of up to six zones and yields one
// result transaction with the brightness percent, the zone and a change flag.
// All work runs on one shared 31 x 31 multiplier with a registered product,
// a restoring divider that retires one quotient bit per cycle, and a small
// sequencer; s_ready is high only while the sequencer is idle. A linear zone
// steps from one accepted sample to the next through the hysteresis check,
// the zone search one zone at a time, setup, the product and the divider
// load, the divide, the load of the output register and an idle state in
// which the next sample is taken. A logarithmic zone adds the 24 squaring
// steps of the two logarithms, each a multiply state and an adjust state;
// a zero logarithm span skips the product and the divide. A zone with an
// empty lux span finishes right after selection. A finished result sits in
// an output register, so the next sample can be accepted while it waits;
// a result that cannot be handed over holds the sequencer until the output
// register frees up.
// Configuration is a plain write port; write it only while the block is idle.
module lux_zone_brightness_mapper (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [lzbm_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [lzbm_pkg::ZONE_WORD_W-1:0]      cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lzbm_pkg::LUX_IN_W-1:0]  s_lux_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lzbm_pkg::PCT_W-1:0]            m_brightness_pct,
    output logic [lzbm_pkg::ZIDX_W-1:0]           m_zone_index,
    output logic                                  m_zone_changed
);
    import lzbm_pkg::*;

    // Configuration registers.
    logic [ZONE_WORD_W-1:0] zone_word_reg [MAX_ZONES];
    logic [ZIDX_W-1:0]      zones_in_use_reg;
    logic [HYST_W-1:0]      hyst_reg;

    // Sequencer state and datapath registers.
    state_t              state_reg, state_next;
    logic [LUX_W-1:0]    lux_reg, lux_next;
    logic [ZIDX_W-1:0]   zidx_reg, zidx_next;
    logic [ZIDX_W-1:0]   cur_zone_reg, cur_zone_next;
    logic                zone_known_reg, zone_known_next;
    logic                changed_reg, changed_next;
    logic [MANT_W-1:0]   mant_reg, mant_next;
    logic [LOG_W-1:0]    lres_reg, lres_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                phase_reg, phase_next;
    logic [LUX_W-1:0]    num_reg, num_next;
    logic [LUX_W-1:0]    den_reg, den_next;
    logic [LUX_W-1:0]    span_reg, span_next;
    logic                neg_reg, neg_next;
    logic [PCT_W-1:0]    bmin_reg, bmin_next;
    logic [PCT_W-1:0]    adiff_reg, adiff_next;
    logic [DIVD_W-1:0]   quot_reg, quot_next;
    logic [LUX_W-1:0]    rem_reg, rem_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [PCT_W-1:0]    bright_reg, bright_next;
    logic [ZIDX_W-1:0]   zout_reg, zout_next;
    logic                chg_out_reg, chg_out_next;

    // Shared multiplier operands.
    logic [MANT_W-1:0]   mul_a, mul_b;

    zone_t               zone;
    logic [ZIDX_W-1:0]   zone_count;
    logic [LUX100_W-1:0] lux100;
    logic [LUX_W-1:0]    lux_clip;
    logic [LUX_W-1:0]    offset;
    logic [MANT_W:0]     sq_top;
    logic [LOG_W-1:0]    lres_step;
    logic [LOG_W-1:0]    log_diff;
    logic [LUX_W:0]      trial;
    logic signed [RES_W-1:0] result;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_brightness_pct = bright_reg;
    assign m_zone_index     = zout_reg;
    assign m_zone_changed   = chg_out_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ZONES; i++) begin
                zone_word_reg[i] <= '0;
            end
            zones_in_use_reg <= ZIDX_W'(1);
            hyst_reg         <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == REG_ZONES_IN_USE) begin
                zones_in_use_reg <= cfg_wdata[ZIDX_W-1:0];
            end else if (cfg_addr == REG_HYSTERESIS) begin
                hyst_reg <= cfg_wdata[HYST_W-1:0];
            end else if (int'(cfg_addr) < MAX_ZONES) begin
                zone_word_reg[cfg_addr] <= cfg_wdata;
            end
        end
    end

    // A zone count of zero acts as one; counts above the zone total saturate.
    always_comb begin
        if (zones_in_use_reg == '0) begin
            zone_count = ZIDX_W'(1);
        end else if (int'(zones_in_use_reg) > MAX_ZONES) begin
            zone_count = ZIDX_W'(MAX_ZONES);
        end else begin
            zone_count = zones_in_use_reg;
        end
    end

    // Single read port into the zone registers, steered by the sequencer.
    assign zone   = zone_t'(zone_word_reg[zidx_reg]);
    assign lux100 = (LUX100_W'(lux_reg) << 6) + (LUX100_W'(lux_reg) << 5)
                  + (LUX100_W'(lux_reg) << 2);

    // Shared multiplier with a registered product.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HYST_LO: begin
                // A widening above one hundred percent drops the lower bound
                // below zero, which a zero product reproduces.
                mul_a = MANT_W'(zone.lux_min);
                if (int'(hyst_reg) <= PCT_FULL) begin
                    mul_b = MANT_W'(PCT_FULL) - MANT_W'(hyst_reg);
                end
            end
            ST_HYST_HI: begin
                mul_a = MANT_W'(zone.lux_max);
                mul_b = MANT_W'(PCT_FULL) + MANT_W'(hyst_reg);
            end
            ST_LOG_SQ: begin
                mul_a = mant_reg;
                mul_b = mant_reg;
            end
            ST_MUL: begin
                mul_a = MANT_W'(num_reg);
                mul_b = MANT_W'(adiff_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Sequencer: next state and datapath.
    always_comb begin
        state_next      = state_reg;
        lux_next        = lux_reg;
        zidx_next       = zidx_reg;
        cur_zone_next   = cur_zone_reg;
        zone_known_next = zone_known_reg;
        changed_next    = changed_reg;
        mant_next       = mant_reg;
        lres_next       = lres_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        span_next       = span_reg;
        neg_next        = neg_reg;
        bmin_next       = bmin_reg;
        adiff_next      = adiff_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        bright_next     = bright_reg;
        zout_next       = zout_reg;
        chg_out_next    = chg_out_reg;

        lux_clip = (lux_reg < zone.lux_max) ? lux_reg : zone.lux_max;
        if (lux_clip < zone.lux_min) begin
            lux_clip = zone.lux_min;
        end
        offset    = lux_clip - zone.lux_min;
        sq_top    = prod_reg[MANT_BITS +: MANT_W + 1];
        lres_step = {lres_reg[LOG_W-2:0], sq_top[MANT_W]};
        log_diff  = lres_step - LOG_W'(LOG_ONE);
        trial     = {rem_reg, quot_reg[DIVD_W-1]} - {1'b0, den_reg};
        result    = neg_reg ? RES_W'(bmin_reg) - RES_W'(quot_reg)
                            : RES_W'(bmin_reg) + RES_W'(quot_reg);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    lux_next = s_lux_sample[LUX_IN_W-1] ? '0 : s_lux_sample[LUX_W-1:0];
                    if (zone_known_reg && hyst_reg != '0 && cur_zone_reg < zone_count) begin
                        zidx_next  = cur_zone_reg;
                        state_next = ST_HYST_LO;
                    end else begin
                        zidx_next  = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_HYST_LO: begin
                state_next = ST_HYST_HI;
            end
            ST_HYST_HI: begin
                if (PROD_W'(lux100) >= prod_reg) begin
                    state_next = ST_HYST_CHK;
                end else begin
                    zidx_next  = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_HYST_CHK: begin
                if (PROD_W'(lux100) < prod_reg) begin
                    state_next = ST_MAP;
                end else begin
                    zidx_next  = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // First zone holding the sample wins; the last zone catches the rest.
                if ((lux_reg >= zone.lux_min && lux_reg < zone.lux_max)
                    || zidx_reg == zone_count - ZIDX_W'(1)) begin
                    state_next = ST_MAP;
                end else begin
                    zidx_next = zidx_reg + ZIDX_W'(1);
                end
            end
            ST_MAP: begin
                changed_next    = zone_known_reg && (zidx_reg != cur_zone_reg);
                cur_zone_next   = zidx_reg;
                zone_known_next = 1'b1;
                bmin_next       = zone.pct_lo;
                neg_next        = zone.pct_hi < zone.pct_lo;
                adiff_next      = (zone.pct_hi < zone.pct_lo)
                                ? zone.pct_lo - zone.pct_hi
                                : zone.pct_hi - zone.pct_lo;
                quot_next       = '0;
                span_next       = zone.lux_max - zone.lux_min;
                if (zone.lux_max <= zone.lux_min) begin
                    neg_next   = 1'b0;
                    state_next = ST_OUT;
                end else if (zone.curve_log) begin
                    mant_next  = normalize((LUX_W + 1)'(LUX_ONE) + (LUX_W + 1)'(offset));
                    lres_next  = LOG_W'(msb_pos((LUX_W + 1)'(LUX_ONE) + (LUX_W + 1)'(offset)));
                    step_next  = '0;
                    phase_next = 1'b0;
                    state_next = ST_LOG_SQ;
                end else begin
                    num_next   = offset;
                    den_next   = zone.lux_max - zone.lux_min;
                    state_next = ST_MUL;
                end
            end
            ST_LOG_SQ: begin
                state_next = ST_LOG_ADJ;
            end
            ST_LOG_ADJ: begin
                // One fractional bit per squaring of the mantissa.
                lres_next = lres_step;
                mant_next = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                if (int'(step_reg) == LOG_FRAC_BITS - 1) begin
                    step_next = '0;
                    if (!phase_reg) begin
                        num_next   = LUX_W'(log_diff);
                        mant_next  = normalize((LUX_W + 1)'(LUX_ONE) + (LUX_W + 1)'(span_reg));
                        lres_next  = LOG_W'(msb_pos((LUX_W + 1)'(LUX_ONE)
                                                    + (LUX_W + 1)'(span_reg)));
                        phase_next = 1'b1;
                        state_next = ST_LOG_SQ;
                    end else if (log_diff == '0) begin
                        quot_next  = '0;
                        neg_next   = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        den_next   = LUX_W'(log_diff);
                        state_next = ST_MUL;
                    end
                end else begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_LOG_SQ;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                quot_next  = prod_reg[DIVD_W-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (!trial[LUX_W]) begin
                    rem_next = trial[LUX_W-1:0];
                end else begin
                    rem_next = {rem_reg[LUX_W-2:0], quot_reg[DIVD_W-1]};
                end
                quot_next = {quot_reg[DIVD_W-2:0], !trial[LUX_W]};
                if (int'(cnt_reg) == DIVD_W - 1) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + QCNT_W'(1);
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (result < 0) begin
                        bright_next = '0;
                    end else if (result > RES_W'(PCT_FULL)) begin
                        bright_next = PCT_W'(PCT_FULL);
                    end else begin
                        bright_next = result[PCT_W-1:0];
                    end
                    zout_next    = cur_zone_reg;
                    chg_out_next = changed_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_zone_reg   <= '0;
            zone_known_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_zone_reg   <= cur_zone_next;
            zone_known_reg <= zone_known_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lux_reg     <= lux_next;
        zidx_reg    <= zidx_next;
        changed_reg <= changed_next;
        mant_reg    <= mant_next;
        lres_reg    <= lres_next;
        step_reg    <= step_next;
        phase_reg   <= phase_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        span_reg    <= span_next;
        neg_reg     <= neg_next;
        bmin_reg    <= bmin_next;
        adiff_reg   <= adiff_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        bright_reg  <= bright_next;
        zout_reg    <= zout_next;
        chg_out_reg <= chg_out_next;
    end

    // The clamp must keep every delivered brightness within range.
    a_bright_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_brightness_pct) <= PCT_FULL))
        else $error("brightness above full scale");

    // A delivered zone index always names an existing zone.
    a_zone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_zone_index) < MAX_ZONES))
        else $error("zone index out of range");

    // The sequencer is busy in the cycle after it takes a sample.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample accepted while busy");

    // Once a zone is known it stays known until the next reset.
    a_known_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(zone_known_reg))
        else $error("zone memory lost without reset");

endmodule
